>>> rtl/rbsr_pkg.sv
// Package with shared constants, types and the sort compare function.
`default_nettype none
package rbsr_pkg;

  localparam int unsigned MaxBatchesDef = 64;
  localparam int unsigned OrderW = 8;
  localparam int unsigned DistW  = 32;
  localparam int unsigned KeyW   = 64;
  localparam int unsigned IdxOutW = 6;
  localparam logic [31:0] FlagMask = 32'hc000_0000;

  // Sort pass codes.
  typedef enum logic [1:0] {
    PassNear  = 2'd0,
    PassKey   = 2'd1,
    PassFar   = 2'd2
  } pass_e;

  // Remap id tables, searched in this order for every batch.
  typedef enum logic [1:0] {
    FldShader   = 2'd0,
    FldMaterial = 2'd1,
    FldGeometry = 2'd2
  } field_e;

  typedef enum logic [3:0] {
    StLoad,
    StInit,
    StSortRd,
    StSortWt,
    StSortCmp,
    StRemapRd,
    StRemapWt,
    StRemapFind,
    StRemapWr,
    StEmitRd,
    StEmitWt,
    StEmitOut
  } state_e;

  // True if batch a goes strictly before batch b (a is inserted and comes
  // later in the current order, so exact ties give false and keep that order).
  function automatic logic goes_before(
    input logic [OrderW-1:0] oa, input logic [DistW-1:0] da, input logic [KeyW-1:0] ka,
    input logic [OrderW-1:0] ob, input logic [DistW-1:0] db, input logic [KeyW-1:0] kb,
    input pass_e pass
  );
    logic r;
    r = 1'b0;
    if (oa != ob) begin
      r = oa < ob;
    end else if (pass == PassKey) begin
      if (ka != kb) r = ka < kb;
      else if (da != db) r = da < db;
    end else begin
      if (da != db) r = (pass == PassFar) ? (da > db) : (da < db);
      else if (ka != kb) r = ka < kb;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/rbsr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module rbsr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

>>> rtl/render_batch_sort_remap.sv
// Top level of the draw-batch sorter with dense state-id remapping.
`default_nettype none
// Batches load one per cycle into RAM. The request that carries is_last starts
// the run and the block then holds in_stall_o high until every result is out.
// Ranks are first set to the identity. Sorting is an insertion sort done by one
// comparator that reads one stored batch per compare. In near mode a near pass
// is followed by the remap pass and a key pass; in far mode a single far pass
// runs and no remap is done. The remap pass compares one id table entry per
// cycle, and emission hands out one result at a time, held while the receiver
// stalls. The id tables need no clearing: their fill counts are reset before
// each remap pass.
module render_batch_sort_remap
  import rbsr_pkg::*;
#(
  parameter int unsigned MAX_BATCHES = MaxBatchesDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic              cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [OrderW-1:0] render_order_i,
  input  wire logic [DistW-1:0]  distance_i,
  input  wire logic [KeyW-1:0]   state_key_i,
  input  wire logic              is_last_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [IdxOutW-1:0]     batch_index_o,
  output logic [KeyW-1:0]        new_key_o,
  output logic                   last_out_o
);
  localparam int unsigned AW = $clog2(MAX_BATCHES);
  localparam int unsigned CW = $clog2(MAX_BATCHES + 1);

  state_e st_q, st_d;
  logic mode_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] i_q, i_d;       // outer index / rank counter
  logic [CW-1:0] j_q, j_d;       // insertion position
  logic [CW-1:0] s_q, s_d;       // step within a state / table search index
  field_e fld_q, fld_d;          // which id table is searched
  pass_e pass_q, pass_d;
  logic [AW-1:0] v_q, v_d;       // batch being inserted
  logic [AW-1:0] nb_q, nb_d;     // neighbor batch in the rank list
  logic [OrderW-1:0] vo_q, vo_d;
  logic [DistW-1:0] vd_q, vd_d;
  logic [KeyW-1:0] vk_q, vk_d;
  logic [KeyW-1:0] nk_q, nk_d;
  logic [CW-1:0] shc_q, shc_d, mtc_q, mtc_d, gec_q, gec_d;
  logic [IdxOutW-1:0] obi_q, obi_d;
  logic [KeyW-1:0] ok_q, ok_d;
  logic ol_q, ol_d, ov_q, ov_d;

  // Memory ports.
  logic bw_we; logic [AW-1:0] bw_a, b_ra;
  logic [OrderW-1:0] bw_o, br_o;
  logic [DistW-1:0] bw_d, br_d;
  logic kw_we; logic [AW-1:0] kw_a; logic [KeyW-1:0] kw_k, kr_k;
  logic rw_we; logic [AW-1:0] rw_a, r_ra, rw_v, rr_v;
  logic tw_we; logic [AW-1:0] tw_a, t_ra;
  logic [31:0] tw_v, sh_r; logic [15:0] mt_r, ge_r;

  rbsr_ram #(.Width(OrderW), .Depth(MAX_BATCHES)) u_ord (
    .clk_i, .we_i(bw_we), .waddr_i(bw_a), .wdata_i(bw_o), .raddr_i(b_ra), .rdata_o(br_o));
  rbsr_ram #(.Width(DistW), .Depth(MAX_BATCHES)) u_dist (
    .clk_i, .we_i(bw_we), .waddr_i(bw_a), .wdata_i(bw_d), .raddr_i(b_ra), .rdata_o(br_d));
  rbsr_ram #(.Width(KeyW), .Depth(MAX_BATCHES)) u_key (
    .clk_i, .we_i(kw_we), .waddr_i(kw_a), .wdata_i(kw_k), .raddr_i(b_ra), .rdata_o(kr_k));
  rbsr_ram #(.Width(AW), .Depth(MAX_BATCHES)) u_rank (
    .clk_i, .we_i(rw_we), .waddr_i(rw_a), .wdata_i(rw_v), .raddr_i(r_ra), .rdata_o(rr_v));
  rbsr_ram #(.Width(32), .Depth(MAX_BATCHES)) u_shs (
    .clk_i, .we_i(tw_we && fld_q == FldShader), .waddr_i(tw_a), .wdata_i(tw_v),
    .raddr_i(t_ra), .rdata_o(sh_r));
  rbsr_ram #(.Width(16), .Depth(MAX_BATCHES)) u_mts (
    .clk_i, .we_i(tw_we && fld_q == FldMaterial), .waddr_i(tw_a), .wdata_i(tw_v[15:0]),
    .raddr_i(t_ra), .rdata_o(mt_r));
  rbsr_ram #(.Width(16), .Depth(MAX_BATCHES)) u_ges (
    .clk_i, .we_i(tw_we && fld_q == FldGeometry), .waddr_i(tw_a), .wdata_i(tw_v[15:0]),
    .raddr_i(t_ra), .rdata_o(ge_r));

  assign cfg_ready_o   = (st_q == StLoad);
  assign in_stall_o    = (st_q != StLoad);
  assign out_valid_o   = ov_q;
  assign batch_index_o = obi_q;
  assign new_key_o     = ok_q;
  assign last_out_o    = ol_q;

  // Registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StLoad; mode_q <= 1'b0; cnt_q <= '0; ov_q <= 1'b0;
      i_q <= '0; j_q <= '0; s_q <= '0; fld_q <= FldShader; pass_q <= PassNear;
      shc_q <= '0; mtc_q <= '0; gec_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; ov_q <= ov_d;
      i_q <= i_d; j_q <= j_d; s_q <= s_d; fld_q <= fld_d; pass_q <= pass_d;
      shc_q <= shc_d; mtc_q <= mtc_d; gec_q <= gec_d;
      if (cfg_valid_i && cfg_ready_o) mode_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d; nb_q <= nb_d; vo_q <= vo_d; vd_q <= vd_d; vk_q <= vk_d; nk_q <= nk_d;
    obi_q <= obi_d; ok_q <= ok_d; ol_q <= ol_d;
  end

  // Search helpers for the remap tables.
  logic [31:0] fval; logic [CW-1:0] fcnt; logic fhit;
  always_comb begin
    unique case (fld_q)
      FldShader: begin
        fval = vk_q[63:32]; fcnt = shc_q; fhit = sh_r == vk_q[63:32];
      end
      FldMaterial: begin
        fval = {16'h0, vk_q[31:16]}; fcnt = mtc_q; fhit = mt_r == vk_q[31:16];
      end
      default: begin
        fval = {16'h0, vk_q[15:0]}; fcnt = gec_q; fhit = ge_r == vk_q[15:0];
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    st_d = st_q; cnt_d = cnt_q; i_d = i_q; j_d = j_q; s_d = s_q; fld_d = fld_q;
    pass_d = pass_q; v_d = v_q; nb_d = nb_q; vo_d = vo_q; vd_d = vd_q; vk_d = vk_q;
    nk_d = nk_q; shc_d = shc_q; mtc_d = mtc_q; gec_d = gec_q;
    obi_d = obi_q; ok_d = ok_q; ol_d = ol_q; ov_d = ov_q;
    bw_we = 1'b0; bw_a = cnt_q[AW-1:0]; bw_o = render_order_i; bw_d = distance_i;
    kw_we = 1'b0; kw_a = cnt_q[AW-1:0]; kw_k = state_key_i;
    rw_we = 1'b0; rw_a = i_q[AW-1:0]; rw_v = i_q[AW-1:0];
    tw_we = 1'b0; tw_a = fcnt[AW-1:0]; tw_v = fval;
    b_ra = v_q; r_ra = '0; t_ra = s_q[AW-1:0];

    unique case (st_q)
      StLoad: begin
        if (in_valid_i) begin
          if (cnt_q < CW'(MAX_BATCHES)) begin
            bw_we = 1'b1; kw_we = 1'b1; cnt_d = cnt_q + 1'b1;
          end
          if (is_last_i) begin
            st_d = StInit; i_d = '0;
            pass_d = mode_q ? PassFar : PassNear;
          end
        end
      end
      // Identity ranks.
      StInit: begin
        if (i_q == cnt_q) begin
          i_d = CW'(1); st_d = StSortRd;
        end else begin
          rw_we = 1'b1; i_d = i_q + 1'b1;
        end
      end
      // Pick up rank[i] as the element to insert.
      StSortRd: begin
        if (i_q >= cnt_q) begin
          if (pass_q == PassNear) begin
            i_d = '0; shc_d = '0; mtc_d = '0; gec_d = '0; st_d = StRemapRd;
          end else begin
            i_d = '0; st_d = StEmitRd;
          end
        end else begin
          r_ra = i_q[AW-1:0]; j_d = i_q; s_d = '0; st_d = StSortWt;
        end
      end
      // Step 0 takes the rank to insert, step 1 its batch, step 2 the neighbor
      // rank; step 3 follows a shift and either places the batch or reads on.
      StSortWt: begin
        if (s_q == '0) begin
          v_d = rr_v; b_ra = rr_v; s_d = CW'(1);
        end else if (s_q == CW'(1)) begin
          vo_d = br_o; vd_d = br_d; vk_d = kr_k;
          r_ra = AW'(j_q - 1'b1); s_d = CW'(2);
        end else if (s_q == CW'(2)) begin
          nb_d = rr_v; b_ra = rr_v; st_d = StSortCmp;
        end else if (j_q == '0) begin
          rw_we = 1'b1; rw_a = '0; rw_v = v_q;
          i_d = i_q + 1'b1; st_d = StSortRd;
        end else begin
          r_ra = AW'(j_q - 1'b1); s_d = CW'(2);
        end
      end
      // Neighbor batch data is valid here: shift it up or place the batch.
      StSortCmp: begin
        rw_we = 1'b1; rw_a = j_q[AW-1:0];
        if (goes_before(vo_q, vd_q, vk_q, br_o, br_d, kr_k, pass_q)) begin
          rw_v = nb_q; j_d = j_q - 1'b1; s_d = CW'(3); st_d = StSortWt;
        end else begin
          rw_v = v_q; i_d = i_q + 1'b1; st_d = StSortRd;
        end
      end
      StRemapRd: begin
        if (i_q >= cnt_q) begin
          i_d = CW'(1); pass_d = PassKey; st_d = StSortRd;
        end else begin
          r_ra = i_q[AW-1:0]; s_d = '0; st_d = StRemapWt;
        end
      end
      StRemapWt: begin
        if (s_q == '0) begin
          v_d = rr_v; b_ra = rr_v; s_d = CW'(1);
        end else begin
          vk_d = kr_k; fld_d = FldShader; s_d = '0; t_ra = '0; st_d = StRemapFind;
        end
      end
      // One table entry compared per cycle; data for entry s_q is valid here.
      StRemapFind: begin
        if (s_q >= fcnt || fhit) begin
          // A value not in the table is appended and gets the next id.
          if (s_q >= fcnt && fcnt < CW'(MAX_BATCHES)) begin
            tw_we = 1'b1;
            unique case (fld_q)
              FldShader:   shc_d = shc_q + 1'b1;
              FldMaterial: mtc_d = mtc_q + 1'b1;
              default:     gec_d = gec_q + 1'b1;
            endcase
          end
          unique case (fld_q)
            FldShader:   nk_d[63:32] = 32'(s_q) | (vk_q[63:32] & FlagMask);
            FldMaterial: nk_d[31:16] = 16'(s_q);
            default:     nk_d[15:0] = 16'(s_q);
          endcase
          s_d = '0; t_ra = '0;
          unique case (fld_q)
            FldShader:   fld_d = FldMaterial;
            FldMaterial: fld_d = FldGeometry;
            default:     st_d = StRemapWr;
          endcase
        end else begin
          s_d = s_q + 1'b1; t_ra = AW'(s_q + 1'b1);
        end
      end
      StRemapWr: begin
        kw_we = 1'b1; kw_a = v_q; kw_k = nk_q;
        i_d = i_q + 1'b1; st_d = StRemapRd;
      end
      StEmitRd: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b0;
          if (i_q >= cnt_q) begin
            cnt_d = '0; st_d = StLoad;
          end else begin
            r_ra = i_q[AW-1:0]; st_d = StEmitWt;
          end
        end
      end
      StEmitWt: begin
        b_ra = rr_v; v_d = rr_v; st_d = StEmitOut;
      end
      StEmitOut: begin
        obi_d = IdxOutW'(v_q); ok_d = kr_k; ol_d = (i_q + 1'b1) == cnt_q;
        ov_d = 1'b1; i_d = i_q + 1'b1; st_d = StEmitRd;
      end
      default: begin
        st_d = StLoad;
      end
    endcase
  end
endmodule
`default_nettype wire
